[sv/cicd_pkg.sv]
// Shared types and constants for the complex CIC decimator.
// Register map, field widths, reset values and parameter defaults; no dependencies.
package cicd_pkg;

    // Parameter defaults
    localparam int MAX_ORDER_DEF   = 6;
    localparam int MAX_RATIO_DEF   = 64;
    localparam int MAX_DELAY_DEF   = 2;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int ACC_BITS_DEF    = 58;

    // Configuration port
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 5;
    localparam int IDX_W    = ADDR_W - 2;
    localparam int NUM_REGS = 5;

    localparam logic [IDX_W-1:0] REG_ORDER = 3'd0;
    localparam logic [IDX_W-1:0] REG_RATIO = 3'd1;
    localparam logic [IDX_W-1:0] REG_DELAY = 3'd2;
    localparam logic [IDX_W-1:0] REG_PHASE = 3'd3;
    localparam logic [IDX_W-1:0] REG_GAIN  = 3'd4;

    // Register field widths
    localparam int ORDER_W = 3;
    localparam int RATIO_W = 7;
    localparam int DELAY_W = 2;
    localparam int PHASE_W = 6;
    localparam int GAIN_W  = 32;

    // Gain is Q1.31
    localparam int GAIN_FRAC = 31;

    localparam logic [ORDER_W-1:0] ORDER_RST = 3'd5;
    localparam logic [RATIO_W-1:0] RATIO_RST = 7'd2;
    localparam logic [DELAY_W-1:0] DELAY_RST = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_RST = 6'd0;
    localparam logic [GAIN_W-1:0]  GAIN_RST  = 32'd67108864;

    // Pipeline control shared by every cell
    typedef struct packed {
        logic adv;  // pipeline moves this cycle
        logic clr;  // synchronous clear of all filter state
    } pipe_ctrl_t;

endpackage

[sv/cicd_integ_cell.sv]
// One integrator cell of the CIC cascade, real and imaginary lanes.
// Depends on cicd_pkg for the pipeline control struct.
module cicd_integ_cell #(
    parameter int ACC_BITS = cicd_pkg::ACC_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cicd_pkg::pipe_ctrl_t    ctrl,
    input  logic                    in_valid,
    input  logic [ACC_BITS-1:0]     in_re,
    input  logic [ACC_BITS-1:0]     in_im,
    output logic                    out_valid,
    output logic [ACC_BITS-1:0]     out_re,
    output logic [ACC_BITS-1:0]     out_im
);

    logic                valid_reg;
    logic [ACC_BITS-1:0] acc_re_reg, acc_im_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (ctrl.clr)
        begin
            valid_reg  <= 1'b0;
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (ctrl.adv)
        begin
            valid_reg <= in_valid;
            if (in_valid)
            begin
                // modular accumulate, wraps at ACC_BITS
                acc_re_reg <= acc_re_reg + in_re;
                acc_im_reg <= acc_im_reg + in_im;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_re    = acc_re_reg;
    assign out_im    = acc_im_reg;

endmodule

[sv/cicd_comb_cell.sv]
// One comb cell of the CIC cascade with its differential delay line.
// Depends on cicd_pkg for the pipeline control struct.
module cicd_comb_cell #(
    parameter int ACC_BITS  = cicd_pkg::ACC_BITS_DEF,
    parameter int MAX_DELAY = cicd_pkg::MAX_DELAY_DEF,
    parameter int DW        = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cicd_pkg::pipe_ctrl_t    ctrl,
    input  logic [DW-1:0]           dsel,
    input  logic                    in_valid,
    input  logic [ACC_BITS-1:0]     in_re,
    input  logic [ACC_BITS-1:0]     in_im,
    output logic                    out_valid,
    output logic [ACC_BITS-1:0]     out_re,
    output logic [ACC_BITS-1:0]     out_im
);

    logic                valid_reg;
    logic [ACC_BITS-1:0] res_re_reg, res_im_reg;
    logic [ACC_BITS-1:0] hist_re_reg [MAX_DELAY];
    logic [ACC_BITS-1:0] hist_im_reg [MAX_DELAY];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            for (int k = 0; k < MAX_DELAY; k++)
            begin
                hist_re_reg[k] <= '0;
                hist_im_reg[k] <= '0;
            end
        end
        else if (ctrl.clr)
        begin
            valid_reg <= 1'b0;
            for (int k = 0; k < MAX_DELAY; k++)
            begin
                hist_re_reg[k] <= '0;
                hist_im_reg[k] <= '0;
            end
        end
        else if (ctrl.adv)
        begin
            valid_reg <= in_valid;
            if (in_valid)
            begin
                // newest first; entries past the selected delay are never read
                hist_re_reg[0] <= in_re;
                hist_im_reg[0] <= in_im;
                for (int k = 1; k < MAX_DELAY; k++)
                begin
                    hist_re_reg[k] <= hist_re_reg[k-1];
                    hist_im_reg[k] <= hist_im_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv && in_valid)
        begin
            res_re_reg <= in_re - hist_re_reg[dsel];
            res_im_reg <= in_im - hist_im_reg[dsel];
        end
    end

    assign out_valid = valid_reg;
    assign out_re    = res_re_reg;
    assign out_im    = res_im_reg;

endmodule

[sv/cicd_scale.sv]
// Output gain stage: sign-magnitude split, Q1.31 multiply in two partial
// products, floor shift and saturation. Depends on cicd_pkg.
module cicd_scale #(
    parameter int ACC_BITS    = cicd_pkg::ACC_BITS_DEF,
    parameter int SAMPLE_BITS = cicd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  cicd_pkg::pipe_ctrl_t            ctrl,
    input  logic [cicd_pkg::GAIN_W-1:0]     gain,
    input  logic                            in_valid,
    input  logic [ACC_BITS-1:0]             in_re,
    input  logic [ACC_BITS-1:0]             in_im,
    output logic                            res_valid,
    output logic signed [SAMPLE_BITS-1:0]   res_re,
    output logic signed [SAMPLE_BITS-1:0]   res_im
);

    localparam int GW = cicd_pkg::GAIN_W;
    localparam int FR = cicd_pkg::GAIN_FRAC;
    localparam int MW = (ACC_BITS > FR + 1) ? ACC_BITS : FR + 1;
    localparam int HW = MW - FR;
    localparam int PHW = HW + GW;
    localparam int PLW = FR + GW;
    localparam int QW = PHW + 1;
    localparam logic [QW-1:0] POS_MAX = QW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic [QW-1:0] NEG_MAX = POS_MAX + QW'(1);

    logic                  s1_valid_reg, s2_valid_reg;
    logic [1:0]            s1_neg_reg, s2_neg_reg;
    logic [MW-1:0]         s1_mag_reg [2];
    logic [PHW-1:0]        s2_ph_reg [2];
    logic [PLW-1:0]        s2_pl_reg [2];
    logic [ACC_BITS-1:0]   lane_in [2];
    logic [SAMPLE_BITS-1:0] lane_out [2];

    assign lane_in[0] = in_re;
    assign lane_in[1] = in_im;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (ctrl.clr)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (ctrl.adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic          neg;
        logic [QW-1:0] q;
        logic [QW-1:0] q_sat;
        logic          rem_nz;

        assign neg = lane_in[l][ACC_BITS-1];

        always_ff @(posedge clk)
        begin
            if (ctrl.adv)
            begin
                // magnitude of the modular word; the most negative value stays exact
                s1_neg_reg[l] <= neg;
                s1_mag_reg[l] <= neg ? MW'(ACC_BITS'(-lane_in[l])) : MW'(lane_in[l]);
                s2_neg_reg[l] <= s1_neg_reg[l];
                s2_ph_reg[l]  <= PHW'(s1_mag_reg[l][MW-1:FR]) * PHW'(gain);
                s2_pl_reg[l]  <= PLW'(s1_mag_reg[l][FR-1:0]) * PLW'(gain);
            end
        end

        // round the magnitude up for negatives so the result floors
        assign rem_nz = |s2_pl_reg[l][FR-1:0];
        assign q = QW'(s2_ph_reg[l]) + QW'(s2_pl_reg[l][PLW-1:FR])
                 + QW'(s2_neg_reg[l] & rem_nz);

        always_comb
        begin
            if (!s2_neg_reg[l])
            begin
                q_sat       = (q > POS_MAX) ? POS_MAX : q;
                lane_out[l] = q_sat[SAMPLE_BITS-1:0];
            end
            else
            begin
                q_sat       = (q > NEG_MAX) ? NEG_MAX : q;
                lane_out[l] = SAMPLE_BITS'(-q_sat);
            end
        end
    end

    assign res_valid = s2_valid_reg;
    assign res_re    = lane_out[0];
    assign res_im    = lane_out[1];

endmodule

[sv/cic_decimator_complex.sv]
// Complex CIC decimator: integrator cell row, frame pick, comb cell row, gain stage.
// Depends on cicd_pkg, cicd_integ_cell, cicd_comb_cell and cicd_scale.
//
// Takes one complex sample per clock while in_stall is low, and returns one result per
// frame of decim_ratio samples. The integrator and comb cascades are rows of pipelined
// cells, each doing one 58-bit add or subtract per clock while not stalled. The selected
// order, clamped to 1..MAX_ORDER, sets how many cells of each row are used.
// A two-entry output buffer lets the pipeline run on while a result waits; in_stall
// rises only once both entries are full and is then held until the first is taken.
// Any write to a defined register clears every integrator, comb line and frame count at
// once; write configuration only while the block is idle. All filter state is in
// flip-flops, so there is no clearing pass after reset.
module cic_decimator_complex #(
    parameter int MAX_ORDER   = cicd_pkg::MAX_ORDER_DEF,
    parameter int MAX_RATIO   = cicd_pkg::MAX_RATIO_DEF,
    parameter int MAX_DELAY   = cicd_pkg::MAX_DELAY_DEF,
    parameter int SAMPLE_BITS = cicd_pkg::SAMPLE_BITS_DEF,
    parameter int ACC_BITS    = cicd_pkg::ACC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // sample input
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [SAMPLE_BITS-1:0]    in_i,
    input  logic signed [SAMPLE_BITS-1:0]    in_q,
    // result output
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [SAMPLE_BITS-1:0]    out_i,
    output logic signed [SAMPLE_BITS-1:0]    out_q,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cicd_pkg::ADDR_W-1:0]      paddr,
    input  logic [cicd_pkg::DATA_W-1:0]      pwdata,
    output logic [cicd_pkg::DATA_W-1:0]      prdata,
    output logic                             pready
);

    localparam int OW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int DW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int PW = (MAX_RATIO > 1) ? $clog2(MAX_RATIO) : 1;
    localparam int RW = $clog2(MAX_RATIO + 1);
    localparam int CW = (RW > cicd_pkg::RATIO_W) ? RW : cicd_pkg::RATIO_W;

    // ---------------------------------------------------------------- registers
    logic [cicd_pkg::ORDER_W-1:0] order_reg;
    logic [cicd_pkg::RATIO_W-1:0] ratio_reg;
    logic [cicd_pkg::DELAY_W-1:0] delay_reg;
    logic [cicd_pkg::PHASE_W-1:0] phase_reg;
    logic [cicd_pkg::GAIN_W-1:0]  gain_reg;

    logic                         cfg_we;
    logic [cicd_pkg::IDX_W-1:0]   cfg_idx;
    cicd_pkg::pipe_ctrl_t         ctrl;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[cicd_pkg::ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= cicd_pkg::ORDER_RST;
            ratio_reg <= cicd_pkg::RATIO_RST;
            delay_reg <= cicd_pkg::DELAY_RST;
            phase_reg <= cicd_pkg::PHASE_RST;
            gain_reg  <= cicd_pkg::GAIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                cicd_pkg::REG_ORDER: order_reg <= pwdata[cicd_pkg::ORDER_W-1:0];
                cicd_pkg::REG_RATIO: ratio_reg <= pwdata[cicd_pkg::RATIO_W-1:0];
                cicd_pkg::REG_DELAY: delay_reg <= pwdata[cicd_pkg::DELAY_W-1:0];
                cicd_pkg::REG_PHASE: phase_reg <= pwdata[cicd_pkg::PHASE_W-1:0];
                cicd_pkg::REG_GAIN:  gain_reg  <= pwdata[cicd_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[cicd_pkg::ADDR_W-1:2])
            cicd_pkg::REG_ORDER: prdata = cicd_pkg::DATA_W'(order_reg);
            cicd_pkg::REG_RATIO: prdata = cicd_pkg::DATA_W'(ratio_reg);
            cicd_pkg::REG_DELAY: prdata = cicd_pkg::DATA_W'(delay_reg);
            cicd_pkg::REG_PHASE: prdata = cicd_pkg::DATA_W'(phase_reg);
            cicd_pkg::REG_GAIN:  prdata = cicd_pkg::DATA_W'(gain_reg);
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------- effective settings
    logic [OW-1:0] ord_idx;
    logic [DW-1:0] dsel;
    logic [CW-1:0] ratio_m1, ph_eff, take;

    always_comb
    begin
        if (order_reg == '0)
            ord_idx = '0;
        else if (int'(order_reg) > MAX_ORDER)
            ord_idx = OW'(MAX_ORDER - 1);
        else
            ord_idx = OW'(order_reg - 1'b1);

        if (delay_reg == '0)
            dsel = '0;
        else if (int'(delay_reg) > MAX_DELAY)
            dsel = DW'(MAX_DELAY - 1);
        else
            dsel = DW'(delay_reg - 1'b1);

        if (ratio_reg == '0)
            ratio_m1 = '0;
        else if (int'(ratio_reg) > MAX_RATIO)
            ratio_m1 = CW'(MAX_RATIO - 1);
        else
            ratio_m1 = CW'(ratio_reg) - CW'(1);

        // clamp the phase to ratio minus one
        ph_eff = (CW'(phase_reg) > ratio_m1) ? ratio_m1 : CW'(phase_reg);
        take   = ratio_m1 - ph_eff;
    end

    // ------------------------------------------------------------ output buffer
    logic                          out_valid_reg, skid_valid_reg;
    logic [SAMPLE_BITS-1:0]        out_i_reg, out_q_reg, skid_i_reg, skid_q_reg;
    logic                          res_valid;
    logic signed [SAMPLE_BITS-1:0] res_i, res_q;
    logic                          out_take, res_in;
    logic                          accept;

    assign ctrl.adv = !skid_valid_reg;
    assign ctrl.clr = cfg_we && (int'(cfg_idx) < cicd_pkg::NUM_REGS);
    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign out_take = out_valid_reg && !out_stall;
    assign res_in   = ctrl.adv && res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
                skid_valid_reg <= 1'b0;
        end
        else if (res_in)
        begin
            if (out_valid_reg && !out_take)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_i_reg <= skid_i_reg;
                out_q_reg <= skid_q_reg;
            end
        end
        else if (res_in)
        begin
            // park in the skid entry when the held result is not taken this cycle
            if (out_valid_reg && !out_take)
            begin
                skid_i_reg <= res_i;
                skid_q_reg <= res_q;
            end
            else
            begin
                out_i_reg <= res_i;
                out_q_reg <= res_q;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_i     = out_i_reg;
    assign out_q     = out_q_reg;

    // ---------------------------------------------------------- integrator row
    logic [MAX_ORDER-1:0] iv_valid;
    logic [ACC_BITS-1:0]  iv_re [MAX_ORDER];
    logic [ACC_BITS-1:0]  iv_im [MAX_ORDER];

    for (genvar k = 0; k < MAX_ORDER; k++)
    begin : g_integ
        logic                cin_valid;
        logic [ACC_BITS-1:0] cin_re, cin_im;

        if (k == 0)
        begin : g_first
            assign cin_valid = accept;
            assign cin_re    = ACC_BITS'(in_i);
            assign cin_im    = ACC_BITS'(in_q);
        end
        else
        begin : g_next
            assign cin_valid = iv_valid[k-1];
            assign cin_re    = iv_re[k-1];
            assign cin_im    = iv_im[k-1];
        end

        cicd_integ_cell #(
            .ACC_BITS (ACC_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .in_valid  (cin_valid),
            .in_re     (cin_re),
            .in_im     (cin_im),
            .out_valid (iv_valid[k]),
            .out_re    (iv_re[k]),
            .out_im    (iv_im[k])
        );
    end

    // ------------------------------------------------------------ frame pick
    logic                tap_valid, tap_hit, tap_last;
    logic [ACC_BITS-1:0] tap_re, tap_im;
    logic [PW-1:0]       pos_reg;
    logic [ACC_BITS-1:0] held_re_reg, held_im_reg;
    logic                cx_valid_reg;
    logic [ACC_BITS-1:0] cx_re_reg, cx_im_reg;

    assign tap_valid = iv_valid[ord_idx];
    assign tap_re    = iv_re[ord_idx];
    assign tap_im    = iv_im[ord_idx];
    assign tap_hit   = (CW'(pos_reg) == take);
    assign tap_last  = (CW'(pos_reg) == ratio_m1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            held_re_reg  <= '0;
            held_im_reg  <= '0;
            cx_valid_reg <= 1'b0;
        end
        else if (ctrl.clr)
        begin
            pos_reg      <= '0;
            held_re_reg  <= '0;
            held_im_reg  <= '0;
            cx_valid_reg <= 1'b0;
        end
        else if (ctrl.adv)
        begin
            cx_valid_reg <= tap_valid && tap_last;
            if (tap_valid)
            begin
                pos_reg <= tap_last ? '0 : pos_reg + 1'b1;
                if (tap_hit)
                begin
                    held_re_reg <= tap_re;
                    held_im_reg <= tap_im;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv && tap_valid && tap_last)
        begin
            // the picked sample may be the frame's last one
            cx_re_reg <= tap_hit ? tap_re : held_re_reg;
            cx_im_reg <= tap_hit ? tap_im : held_im_reg;
        end
    end

    // ---------------------------------------------------------------- comb row
    logic [MAX_ORDER-1:0] cv_valid;
    logic [ACC_BITS-1:0]  cv_re [MAX_ORDER];
    logic [ACC_BITS-1:0]  cv_im [MAX_ORDER];

    for (genvar k = 0; k < MAX_ORDER; k++)
    begin : g_comb
        logic                cin_valid;
        logic [ACC_BITS-1:0] cin_re, cin_im;

        if (k == 0)
        begin : g_first
            assign cin_valid = cx_valid_reg;
            assign cin_re    = cx_re_reg;
            assign cin_im    = cx_im_reg;
        end
        else
        begin : g_next
            assign cin_valid = cv_valid[k-1];
            assign cin_re    = cv_re[k-1];
            assign cin_im    = cv_im[k-1];
        end

        cicd_comb_cell #(
            .ACC_BITS  (ACC_BITS),
            .MAX_DELAY (MAX_DELAY),
            .DW        (DW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .dsel      (dsel),
            .in_valid  (cin_valid),
            .in_re     (cin_re),
            .in_im     (cin_im),
            .out_valid (cv_valid[k]),
            .out_re    (cv_re[k]),
            .out_im    (cv_im[k])
        );
    end

    // ---------------------------------------------------------------- gain
    cicd_scale #(
        .ACC_BITS    (ACC_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .gain      (gain_reg),
        .in_valid  (cv_valid[ord_idx]),
        .in_re     (cv_re[ord_idx]),
        .in_im     (cv_im[ord_idx]),
        .res_valid (res_valid),
        .res_re    (res_i),
        .res_im    (res_q)
    );

endmodule
